// ===== rtl/core/camint_pkg.sv =====
// Shared types and constants for the camera intervalometer control block.
// Holds the packed item layouts, mode and status codes and register indexes.
// No dependencies.
package camint_pkg;

	typedef logic [2:0] mode_t;
	typedef logic [2:0] status_t;
	typedef logic [0:0] cfg_idx_t;

	localparam mode_t MODE_MENU   = 3'd0;
	localparam mode_t MODE_SINGLE = 3'd1;
	localparam mode_t MODE_LAPSE  = 3'd2;
	localparam mode_t MODE_TRAIL  = 3'd3;
	localparam mode_t MODE_BULB   = 3'd4;

	localparam status_t ST_CHOOSE      = 3'd0;
	localparam status_t ST_DISCONN     = 3'd1;
	localparam status_t ST_READY_SINGLE = 3'd2;
	localparam status_t ST_TRIG_FAIL   = 3'd3;
	localparam status_t ST_READY_LAPSE = 3'd4;
	localparam status_t ST_SHOOTING    = 3'd5;
	localparam status_t ST_READY_TRAIL = 3'd6;
	localparam status_t ST_READY_BULB  = 3'd7;

	localparam cfg_idx_t REG_BULB_STEP    = 1'd0;
	localparam cfg_idx_t REG_TRAIL_MARGIN = 1'd1;

	localparam logic [7:0]  BULB_STEP_RESET = 8'd10;
	localparam logic [4:0]  MARGIN_RESET    = 5'd11;
	// Star trail compares seconds in tenths against margin times interval.
	localparam logic [19:0] TRAIL_SCALE     = 20'd10;
	// Highest menu entry that maps to a shooting mode.
	localparam logic [3:0]  LAST_MODE_ENTRY = 4'd4;
	localparam logic [15:0] SAT16           = 16'hFFFF;
	localparam logic signed [15:0] IVAL_MAX = 16'sh7FFF;

	// Input item, lowest field in the lowest bit.
	typedef struct packed {
		logic trigger_ok;
		logic b_long_released;
		logic pwr_released;
		logic b_released;
		logic a_released;
		logic camera_connected;
		logic second_tick;
	} poll_t;

	// Result item, lowest field in the lowest bit.
	typedef struct packed {
		logic [15:0]        elapsed_secs;
		logic [15:0]        picture_count;
		status_t            status_code;
		logic signed [15:0] shown_value;
		mode_t              cur_mode;
		logic               fire_focus;
		logic               fire_shutter;
	} result_t;

endpackage

// ===== rtl/core/camera_intervalometer_control.sv =====
// Camera intervalometer control: one poll in, one result out.
// Depends on camint_pkg for item layouts, mode and status codes.
//
// Each accepted item is one poll of buttons, a seconds tick and camera link
// status. A poll is registered, evaluated against the controller state in a
// single cycle, and the result lands in an output register; the block takes
// one poll per clock while the output side accepts results.
// Throughput is limited only by the output side: while a result waits, the
// pipeline holds. Configuration writes take effect from the next poll and
// are expected only while no poll is in flight.
module camera_intervalometer_control #(
	parameter int unsigned MENU_ENTRIES = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// [0] second_tick, [1] camera_connected, [2] a_released, [3] b_released,
	// [4] pwr_released, [5] b_long_released, [6] trigger_ok, [7] zero
	input  logic [7:0]           s_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// [0] fire_shutter, [1] fire_focus, [4:2] cur_mode, [20:5] shown_value,
	// [23:21] status_code, [39:24] picture_count, [55:40] elapsed_secs
	output logic [55:0]          m_tdata,
	input  logic                 cfg_we,
	input  camint_pkg::cfg_idx_t cfg_index,
	input  logic [7:0]           cfg_data
);
	import camint_pkg::*;

	localparam logic [3:0] MENU_LAST = 4'(MENU_ENTRIES);

	poll_t   in_s1;
	logic    vld_s1;
	result_t out_q;
	logic    out_vld_q;
	logic    advance;

	logic [7:0]  bulb_step_q;
	logic [4:0]  margin_q;
	mode_t       mode_q;
	logic [2:0]  menu_idx_q;
	logic        entering_q;
	logic        shooting_q;
	logic signed [15:0] interval_q;
	logic [15:0] pic_q;
	logic [15:0] secs_q;
	status_t     status_q;

	mode_t       n_mode;
	logic [2:0]  n_menu;
	logic        n_entering;
	logic        n_shooting;
	logic signed [15:0] n_interval;
	logic [15:0] n_pic;
	logic [15:0] n_secs;
	status_t     n_status;
	logic        shut;
	logic        focus;

	logic [15:0] secs_t;
	logic [3:0]  menu_inc;
	status_t     ready_code;
	logic signed [15:0] step;
	logic signed [16:0] ival_up;
	logic [19:0] trail_lhs;
	logic signed [21:0] trail_rhs;
	logic        due;
	logic [15:0] pic_inc;

	assign advance  = vld_s1 && (!out_vld_q || m_tready);
	assign s_tready = !vld_s1 || advance;
	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_q;

	always_comb begin
		secs_t    = (in_s1.second_tick && secs_q != SAT16) ? secs_q + 16'd1 : secs_q;
		menu_inc  = {1'b0, menu_idx_q} + 4'd1;
		pic_inc   = (pic_q != SAT16) ? pic_q + 16'd1 : pic_q;
		step      = (mode_q == MODE_BULB) ? $signed({8'd0, bulb_step_q}) : 16'sd1;
		ival_up   = 17'(interval_q) + 17'(step);
		trail_lhs = 20'(secs_t) * TRAIL_SCALE;
		trail_rhs = $signed(22'({1'b0, margin_q})) * 22'(interval_q);
		if (mode_q == MODE_TRAIL) begin
			due = $signed({2'b00, trail_lhs}) > trail_rhs;
		end else begin
			due = $signed({1'b0, secs_t}) > 17'(interval_q);
		end
		unique case (mode_q)
			MODE_LAPSE: ready_code = ST_READY_LAPSE;
			MODE_TRAIL: ready_code = ST_READY_TRAIL;
			default:    ready_code = ST_READY_BULB;
		endcase

		n_mode     = mode_q;
		n_menu     = menu_idx_q;
		n_entering = entering_q;
		n_shooting = shooting_q;
		n_interval = interval_q;
		n_pic      = pic_q;
		n_secs     = secs_t;
		n_status   = status_q;
		shut       = 1'b0;
		focus      = 1'b0;

		if (mode_q != MODE_MENU && !in_s1.camera_connected) begin
			n_status   = ST_DISCONN;
			n_interval = -16'sd1;
			if (in_s1.a_released && !in_s1.b_released && !in_s1.pwr_released) begin
				focus = 1'b1;
			end else if (in_s1.b_long_released) begin
				n_shooting = 1'b0;
				n_mode     = MODE_MENU;
				n_menu     = 3'd1;
				n_status   = ST_CHOOSE;
			end
		end else if (mode_q == MODE_MENU) begin
			if (in_s1.b_released) begin
				n_menu = (menu_inc > MENU_LAST) ? 3'd1 : menu_inc[2:0];
			end else if (in_s1.pwr_released) begin
				if (menu_idx_q <= 3'd1 || {1'b0, menu_idx_q} > MENU_LAST) begin
					n_menu = MENU_LAST[2:0];
				end else begin
					n_menu = menu_idx_q - 3'd1;
				end
			end else if (in_s1.a_released && menu_idx_q != 3'd0
					&& {1'b0, menu_idx_q} <= LAST_MODE_ENTRY) begin
				n_entering = 1'b1;
				n_mode     = menu_idx_q;
			end
		end else if (mode_q == MODE_SINGLE) begin
			if (entering_q) begin
				n_status   = ST_READY_SINGLE;
				n_interval = 16'sd0;
				n_entering = 1'b0;
			end else if (in_s1.a_released && !in_s1.b_released && !in_s1.pwr_released) begin
				shut  = 1'b1;
				n_pic = pic_inc;
				if (!in_s1.trigger_ok) begin
					n_status = ST_TRIG_FAIL;
				end
			end else if (in_s1.b_long_released) begin
				n_pic    = 16'd0;
				n_mode   = MODE_MENU;
				n_menu   = 3'd1;
				n_status = ST_CHOOSE;
			end
		end else if (mode_q == MODE_LAPSE || mode_q == MODE_TRAIL || mode_q == MODE_BULB) begin
			if (entering_q) begin
				n_status   = ready_code;
				n_interval = 16'sd0;
				n_entering = 1'b0;
			end else if (in_s1.b_long_released && !shooting_q) begin
				n_interval = 16'sd0;
				if (mode_q != MODE_BULB) begin
					n_pic = 16'd0;
				end
				n_shooting = 1'b0;
				n_mode     = MODE_MENU;
				n_menu     = 3'd1;
				n_status   = ST_CHOOSE;
			end else if (in_s1.b_released && !shooting_q) begin
				if (interval_q <= 16'sd0) begin
					n_interval = step;
				end else if (ival_up > 17'(IVAL_MAX)) begin
					n_interval = IVAL_MAX;
				end else begin
					n_interval = ival_up[15:0];
				end
			end else if (in_s1.pwr_released && !shooting_q) begin
				n_interval = (interval_q <= step) ? 16'sd0 : interval_q - step;
			end else if (in_s1.a_released && !shooting_q) begin
				n_status   = in_s1.trigger_ok ? ST_SHOOTING : ST_TRIG_FAIL;
				n_shooting = 1'b1;
				n_secs     = 16'd0;
				shut       = 1'b1;
			end else if (shooting_q) begin
				if (mode_q == MODE_BULB) begin
					if (due) begin
						shut       = 1'b1;
						n_status   = ST_READY_BULB;
						n_shooting = 1'b0;
					end
				end else begin
					if (due) begin
						shut   = 1'b1;
						n_pic  = pic_inc;
						n_secs = 16'd0;
						if (!in_s1.trigger_ok) begin
							n_status = ST_TRIG_FAIL;
						end
					end
					// A press during a run stops it and drops the count.
					if (in_s1.a_released) begin
						n_status   = ready_code;
						n_shooting = 1'b0;
						n_pic      = 16'd0;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1      <= 1'b0;
			out_vld_q   <= 1'b0;
			bulb_step_q <= BULB_STEP_RESET;
			margin_q    <= MARGIN_RESET;
			mode_q      <= MODE_MENU;
			menu_idx_q  <= 3'd1;
			entering_q  <= 1'b0;
			shooting_q  <= 1'b0;
			interval_q  <= 16'sd0;
			pic_q       <= 16'd0;
			secs_q      <= 16'd0;
			status_q    <= ST_CHOOSE;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_BULB_STEP:    bulb_step_q <= cfg_data;
					REG_TRAIL_MARGIN: margin_q    <= cfg_data[4:0];
					default: ;
				endcase
			end
			if (s_tready) begin
				vld_s1 <= s_tvalid;
			end
			if (advance) begin
				out_vld_q  <= 1'b1;
				mode_q     <= n_mode;
				menu_idx_q <= n_menu;
				entering_q <= n_entering;
				shooting_q <= n_shooting;
				interval_q <= n_interval;
				pic_q      <= n_pic;
				secs_q     <= n_secs;
				status_q   <= n_status;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			in_s1 <= poll_t'(s_tdata[6:0]);
		end
		if (advance) begin
			out_q.fire_shutter  <= shut;
			out_q.fire_focus    <= focus;
			out_q.cur_mode      <= n_mode;
			out_q.shown_value   <= (n_mode == MODE_MENU) ? $signed({13'd0, n_menu}) : n_interval;
			out_q.status_code   <= n_status;
			out_q.picture_count <= n_pic;
			out_q.elapsed_secs  <= n_secs;
		end
	end

	a_menu_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		menu_idx_q != 3'd0 && {1'b0, menu_idx_q} <= MENU_LAST)
		else $error("menu index left its range");

	a_pulse_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> !(out_q.fire_shutter && out_q.fire_focus))
		else $error("shutter and focus fired together");

	a_focus_disconn: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q && out_q.fire_focus |-> out_q.status_code == ST_DISCONN)
		else $error("focus pulse outside disconnected handling");

	a_drain_on_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready && vld_s1 |-> advance)
		else $error("input taken while the held poll cannot move on");

endmodule
